/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the glyph renderer datapath.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

/* rtl/tcgr_pkg.sv */
// ----------------------------------------------------------------------------
// Glyph renderer package
// Types, constants and helpers shared by the text console glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

    localparam int FONT_AW        = 14;
    localparam int FONT_ENTRIES   = 1 << FONT_AW;
    localparam int MAX_GLYPH_SIDE = 8;
    localparam int GC_W           = (MAX_GLYPH_SIDE > 1) ? $clog2(MAX_GLYPH_SIDE) : 1;
    localparam int IDX_W          = 16;
    localparam int SIDE_W         = 4;
    localparam int COL_W          = 7;
    localparam int ROW_W          = 6;
    localparam int PX_W           = 10;
    localparam int PY_W           = 9;
    localparam int OX_W           = COL_W + SIDE_W;
    localparam int OY_W           = ROW_W + SIDE_W;
    localparam int CWCH_W         = 2 * SIDE_W - 1;
    localparam int TAB_STEP       = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR_FLAGS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLUMNS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ROWS    = 3'd6;

    localparam logic [7:0]        RST_FG_COLOR     = 8'd7;
    localparam logic [7:0]        RST_BG_COLOR     = 8'd0;
    localparam logic [7:0]        RST_ATTR_FLAGS   = 8'd0;
    localparam logic [SIDE_W-1:0] RST_GLYPH_WIDTH  = 4'd8;
    localparam logic [SIDE_W-1:0] RST_GLYPH_HEIGHT = 4'd8;
    localparam logic [COL_W-1:0]  RST_TEXT_COLUMNS = 7'd40;
    localparam logic [ROW_W-1:0]  RST_TEXT_ROWS    = 6'd25;

    localparam int ATTR_HFLIP    = 0;
    localparam int ATTR_VFLIP    = 1;
    localparam int ATTR_CW90     = 2;
    localparam int ATTR_CCW90    = 3;
    localparam int ATTR_REVERSE  = 4;
    localparam int ATTR_MASKED   = 5;
    localparam int ATTR_NODRAW   = 6;
    localparam int ATTR_NOSCROLL = 7;

    localparam logic [7:0] CHAR_BS  = 8'd8;
    localparam logic [7:0] CHAR_TAB = 8'd9;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_CR  = 8'd13;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_COLOR  = 2'd1;
    localparam logic [1:0] KIND_INVERT = 2'd2;
    localparam logic [1:0] KIND_KEEP   = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [7:0]  char_code;
        logic [13:0] font_index;
        logic        font_bit;
    } t_in_word;

    typedef struct packed {
        logic [1:0]      write_kind;
        logic [PX_W-1:0] pixel_x;
        logic [PY_W-1:0] pixel_y;
        logic [7:0]      color;
        logic            scroll_up;
        logic            last;
    } t_out_word;

    typedef struct packed {
        logic [7:0]        fg_color;
        logic [7:0]        bg_color;
        logic [7:0]        attribute_flags;
        logic [SIDE_W-1:0] glyph_width;
        logic [SIDE_W-1:0] glyph_height;
        logic [COL_W-1:0]  text_columns;
        logic [ROW_W-1:0]  text_rows;
    } t_cfg;

    typedef struct packed {
        logic            accept_put;
        logic            font_we;
        logic            setup;
        logic            issue;
        logic            nopix;
        logic            last;
        logic [GC_W-1:0] gx;
        logic [GC_W-1:0] gy;
    } t_dp_cmd;

    typedef struct packed {
        logic            draw;
        logic            can_issue;
        logic [GC_W-1:0] cw_m1;
        logic [GC_W-1:0] ch_m1;
    } t_dp_status;

    function automatic logic [SIDE_W-1:0] side_sat(input logic [SIDE_W-1:0] v);
        return (32'(v) > MAX_GLYPH_SIDE) ? SIDE_W'(MAX_GLYPH_SIDE) : v;
    endfunction

endpackage

/* rtl/tcgr_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module tcgr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tcgr_regs.sv */
// ----------------------------------------------------------------------------
// Glyph renderer configuration registers
// Holds colors, attributes, glyph size and console size.
// ----------------------------------------------------------------------------
module tcgr_regs import tcgr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FG_COLOR:     n_cfg.fg_color        = i_cfg_data;
                CFG_BG_COLOR:     n_cfg.bg_color        = i_cfg_data;
                CFG_ATTR_FLAGS:   n_cfg.attribute_flags = i_cfg_data;
                CFG_GLYPH_WIDTH:  n_cfg.glyph_width     = i_cfg_data[SIDE_W-1:0];
                CFG_GLYPH_HEIGHT: n_cfg.glyph_height    = i_cfg_data[SIDE_W-1:0];
                CFG_TEXT_COLUMNS: n_cfg.text_columns    = i_cfg_data[COL_W-1:0];
                CFG_TEXT_ROWS:    n_cfg.text_rows       = i_cfg_data[ROW_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fg_color        <= RST_FG_COLOR;
            r_cfg.bg_color        <= RST_BG_COLOR;
            r_cfg.attribute_flags <= RST_ATTR_FLAGS;
            r_cfg.glyph_width     <= RST_GLYPH_WIDTH;
            r_cfg.glyph_height    <= RST_GLYPH_HEIGHT;
            r_cfg.text_columns    <= RST_TEXT_COLUMNS;
            r_cfg.text_rows       <= RST_TEXT_ROWS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/tcgr_ctrl.sv */
// ----------------------------------------------------------------------------
// Glyph renderer controller
// Sequences word acceptance, glyph setup and the pixel raster scan.
// ----------------------------------------------------------------------------
module tcgr_ctrl import tcgr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_operation,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_DRAW  = 2'd2;
    localparam logic [1:0] S_EMPTY = 2'd3;

    logic [1:0]      r_state;
    logic [1:0]      n_state;
    logic [GC_W-1:0] r_gx;
    logic [GC_W-1:0] n_gx;
    logic [GC_W-1:0] r_gy;
    logic [GC_W-1:0] n_gy;
    logic            col_end;
    logic            row_end;

    assign col_end = (r_gx == i_status.cw_m1);
    assign row_end = (r_gy == i_status.ch_m1);

    always_comb begin
        o_cmd    = '0;
        o_cmd.gx = r_gx;
        o_cmd.gy = r_gy;
        n_state  = r_state;
        n_gx     = r_gx;
        n_gy     = r_gy;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_operation == OP_LOAD) begin
                        o_cmd.font_we = 1'b1;
                    end else begin
                        o_cmd.accept_put = 1'b1;
                        n_state = i_status.draw ? S_SETUP : S_EMPTY;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_gx = '0;
                n_gy = '0;
                n_state = S_DRAW;
            end
            S_DRAW: begin
                if (i_status.can_issue) begin
                    o_cmd.issue = 1'b1;
                    o_cmd.last = col_end && row_end;
                    if (col_end) begin
                        n_gx = '0;
                        n_gy = r_gy + GC_W'(1);
                        if (row_end) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_gx = r_gx + GC_W'(1);
                    end
                end
            end
            S_EMPTY: begin
                if (i_status.can_issue) begin
                    o_cmd.issue = 1'b1;
                    o_cmd.nopix = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gx    <= '0;
            r_gy    <= '0;
        end else begin
            r_state <= n_state;
            r_gx    <= n_gx;
            r_gy    <= n_gy;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* rtl/tcgr_datapath.sv */
// ----------------------------------------------------------------------------
// Glyph renderer datapath
// Cursor update, font address generation, font memory and result pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcgr_datapath import tcgr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_in_word   i_in,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_out_word  o_out
);

    // Cursor state and the snapshot taken when a character is accepted.
    logic [COL_W-1:0]  r_cur_col;
    logic [ROW_W-1:0]  r_cur_row;
    logic [7:0]        r_code;
    logic [COL_W-1:0]  r_cx;
    logic [ROW_W-1:0]  r_cy;
    logic [SIDE_W-1:0] r_cw;
    logic [SIDE_W-1:0] r_ch;
    logic [CWCH_W-1:0] r_cwch;
    logic              r_scroll;
    logic [IDX_W-1:0]  r_off;
    logic [OX_W-1:0]   r_ox;
    logic [OY_W-1:0]   r_oy;

    logic [SIDE_W-1:0] cw_in;
    logic [SIDE_W-1:0] ch_in;
    logic              on_screen;
    logic              printable;
    logic              scroll;
    logic [COL_W:0]    nx;
    logic [ROW_W:0]    ny;

    logic [IDX_W-1:0]  gx_w;
    logic [IDX_W-1:0]  gy_w;
    logic [IDX_W-1:0]  cw_w;
    logic [IDX_W-1:0]  ch_w;
    logic [IDX_W-1:0]  tx;
    logic [IDX_W-1:0]  ty;
    logic [IDX_W-1:0]  tmp;
    logic [IDX_W-1:0]  font_idx;
    logic [OX_W-1:0]   x_sum;
    logic [OY_W-1:0]   y_sum;

    logic              font_we;
    logic              font_re;
    logic              font_rbit;

    logic              r_s1_v;
    logic              r_s1_nopix;
    logic              r_s1_last;
    logic              r_s1_scroll;
    logic [PX_W-1:0]   r_s1_x;
    logic [PY_W-1:0]   r_s1_y;

    logic              r_o_v;
    t_out_word         r_o;
    t_out_word         res;
    logic              out_free;
    logic              s1_adv;

    assign cw_in     = side_sat(i_cfg.glyph_width);
    assign ch_in     = side_sat(i_cfg.glyph_height);
    assign on_screen = (r_cur_row < i_cfg.text_rows);

    always_comb begin
        nx = {1'b0, r_cur_col};
        ny = {1'b0, r_cur_row};
        printable = 1'b0;
        unique case (i_in.char_code)
            CHAR_BS: begin
                if (r_cur_col != '0) begin
                    nx = nx - (COL_W+1)'(1);
                end
            end
            CHAR_TAB: begin
                nx = (nx + (COL_W+1)'(TAB_STEP)) & ~(COL_W+1)'(TAB_STEP - 1);
            end
            CHAR_CR: begin
                nx = '0;
            end
            CHAR_LF: begin
                nx = '0;
                ny = ny + (ROW_W+1)'(1);
            end
            default: begin
                nx = nx + (COL_W+1)'(1);
                printable = 1'b1;
            end
        endcase
        if (nx >= {1'b0, i_cfg.text_columns}) begin
            nx = '0;
            ny = ny + (ROW_W+1)'(1);
        end
        scroll = (ny >= {1'b0, i_cfg.text_rows}) && !i_cfg.attribute_flags[ATTR_NOSCROLL];
        if (scroll) begin
            ny = ny - (ROW_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
        end else if (i_cmd.accept_put && on_screen) begin
            r_cur_col <= nx[COL_W-1:0];
            r_cur_row <= ny[ROW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_put) begin
            r_code   <= i_in.char_code;
            r_cx     <= r_cur_col;
            r_cy     <= r_cur_row;
            r_cw     <= cw_in;
            r_ch     <= ch_in;
            r_cwch   <= CWCH_W'({{SIDE_W{1'b0}}, cw_in} * {{SIDE_W{1'b0}}, ch_in});
            r_scroll <= on_screen && scroll;
        end
        if (i_cmd.setup) begin
            r_off <= IDX_W'({{(IDX_W-8){1'b0}}, r_code} * {{(IDX_W-CWCH_W){1'b0}}, r_cwch});
            r_ox  <= OX_W'({{SIDE_W{1'b0}}, r_cx} * {{COL_W{1'b0}}, r_cw});
            r_oy  <= OY_W'({{SIDE_W{1'b0}}, r_cy} * {{ROW_W{1'b0}}, r_ch});
        end
    end

    // Glyph transform in the order hflip, vflip, cw90, ccw90, modulo 2^16.
    always_comb begin
        gx_w = IDX_W'(i_cmd.gx);
        gy_w = IDX_W'(i_cmd.gy);
        cw_w = IDX_W'(r_cw);
        ch_w = IDX_W'(r_ch);
        tx = gx_w;
        ty = gy_w;
        tmp = '0;
        if (i_cfg.attribute_flags[ATTR_HFLIP]) begin
            tx = cw_w - IDX_W'(1) - gx_w;
        end
        if (i_cfg.attribute_flags[ATTR_VFLIP]) begin
            ty = ch_w - IDX_W'(1) - gy_w;
        end
        if (i_cfg.attribute_flags[ATTR_CW90]) begin
            tmp = cw_w - IDX_W'(1) - tx;
            tx = ty;
            ty = tmp;
        end
        if (i_cfg.attribute_flags[ATTR_CCW90]) begin
            tmp = ch_w - IDX_W'(1) - ty;
            ty = tx;
            tx = tmp;
        end
        font_idx = r_off + tx + ty * cw_w;
    end

    assign font_we = i_cmd.font_we && (32'(i_in.font_index) < 32'(FONT_ENTRIES));
    assign font_re = i_cmd.issue && !i_cmd.nopix;

    tcgr_ram #(
        .WIDTH (1),
        .DEPTH (FONT_ENTRIES)
    ) u_font_ram (
        .i_clk   (i_clk),
        .i_we    (font_we),
        .i_waddr (FONT_AW'(i_in.font_index)),
        .i_wdata (i_in.font_bit),
        .i_re    (font_re),
        .i_raddr (font_idx[FONT_AW-1:0]),
        .o_rdata (font_rbit)
    );

    assign out_free = !r_o_v || i_out_ready;
    assign s1_adv   = r_s1_v && out_free;
    assign x_sum    = r_ox + OX_W'(i_cmd.gx);
    assign y_sum    = r_oy + OY_W'(i_cmd.gy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_cmd.issue) begin
            r_s1_v <= 1'b1;
        end else if (s1_adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_s1_nopix  <= i_cmd.nopix;
            r_s1_last   <= i_cmd.last;
            r_s1_scroll <= i_cmd.last && r_scroll;
            r_s1_x      <= i_cmd.nopix ? '0 : x_sum[PX_W-1:0];
            r_s1_y      <= i_cmd.nopix ? '0 : y_sum[PY_W-1:0];
        end
    end

    always_comb begin
        res.pixel_x   = r_s1_x;
        res.pixel_y   = r_s1_y;
        res.scroll_up = r_s1_scroll;
        res.last      = r_s1_last;
        priority if (r_s1_nopix) begin
            res.write_kind = KIND_NONE;
            res.color      = '0;
        end else if (i_cfg.attribute_flags[ATTR_NODRAW]) begin
            res.write_kind = KIND_COLOR;
            res.color      = i_cfg.bg_color;
        end else if (font_rbit) begin
            if (i_cfg.attribute_flags[ATTR_REVERSE]) begin
                res.write_kind = KIND_INVERT;
                res.color      = '0;
            end else begin
                res.write_kind = KIND_COLOR;
                res.color      = i_cfg.fg_color;
            end
        end else if (i_cfg.attribute_flags[ATTR_MASKED] && (i_cfg.bg_color == '0)) begin
            res.write_kind = KIND_KEEP;
            res.color      = '0;
        end else begin
            res.write_kind = KIND_COLOR;
            res.color      = i_cfg.bg_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (s1_adv) begin
            r_o_v <= 1'b1;
        end else if (i_out_ready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o <= res;
        end
    end

    assign o_status.draw      = on_screen && printable && (cw_in != '0) && (ch_in != '0);
    assign o_status.can_issue = !r_s1_v || out_free;
    assign o_status.cw_m1     = GC_W'(r_cw - SIDE_W'(1));
    assign o_status.ch_m1     = GC_W'(r_ch - SIDE_W'(1));

    assign o_out_valid = r_o_v;
    assign o_out       = r_o;

    `ASSERT_PROP(a_issue_has_room, i_clk, i_rst_n, i_cmd.issue |-> o_status.can_issue)
    `ASSERT_PROP(a_issue_fills_stage, i_clk, i_rst_n, i_cmd.issue |=> r_s1_v)
    `ASSERT_PROP(a_scroll_on_last, i_clk, i_rst_n, (r_o_v && r_o.scroll_up) |-> r_o.last)
    `ASSERT_PROP(a_empty_is_last, i_clk, i_rst_n, (r_o_v && (r_o.write_kind == KIND_NONE)) |-> r_o.last)

endmodule

/* rtl/text_console_glyph_renderer_unit.sv */
// ----------------------------------------------------------------------------
// Text console glyph renderer
// Keeps a text cursor and turns console characters into glyph pixel commands.
//
//   Port group   Direction  Handshake            Word
//   i_in_*       in         valid / ready        t_in_word
//   o_out_*      out        valid / ready        t_out_word
//   i_cfg_*      in         write enable only    index and data
//
// A font load is written as it is accepted. A drawn character is accepted, has
// its glyph offset and origin formed, then issues one pixel a cycle unless the
// output stalls, set by the font memory's single read port. Other puts issue one
// empty word. Reset restores the register defaults and puts the cursor at the
// top left; the font memory is not cleared. A stalled output holds the pixel
// scan, with one read stage and the output register keeping words in flight.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_unit import tcgr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg       cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    tcgr_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tcgr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_data.operation),
        .o_in_ready  (o_in_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tcgr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in        (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data)
    );

endmodule

/* bench/tb_text_console_glyph_renderer_unit.sv */
// ----------------------------------------------------------------------------
// Glyph renderer testbench
// Feeds font loads and console characters through the valid/ready input and
// compares every pixel command word against a cycle-free model of the cursor,
// the font memory and the glyph transforms. Settings are rewritten between
// phases while idle, and both sides stall at random except in one calm phase.
// ----------------------------------------------------------------------------
module tb_text_console_glyph_renderer_unit;
    import tcgr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int IDLE_PCT       = 6;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 80;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 28;
    localparam int CALM_PHASE     = 4;
    localparam int ROW_MAX        = (1 << ROW_W) - 1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_word              in_word = '0;
    logic                  o_out_valid;
    logic                  out_ready = 1'b0;
    t_out_word             o_out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [7:0]        fg_idx = RST_FG_COLOR;
    logic [7:0]        bg_idx = RST_BG_COLOR;
    logic [7:0]        attr_bits = RST_ATTR_FLAGS;
    logic [SIDE_W-1:0] glyph_w = RST_GLYPH_WIDTH;
    logic [SIDE_W-1:0] glyph_h = RST_GLYPH_HEIGHT;
    logic [COL_W-1:0]  console_cols = RST_TEXT_COLUMNS;
    logic [ROW_W-1:0]  console_rows = RST_TEXT_ROWS;
    logic [COL_W-1:0]  cur_col = '0;
    logic [ROW_W-1:0]  cur_row = '0;
    bit                font_bits [FONT_ENTRIES];
    bit                font_known [FONT_ENTRIES];

    t_in_word  console_words_pending [$];
    t_out_word pixel_cmds_due [$];
    logic [7:0] control_codes [4] = '{CHAR_BS, CHAR_TAB, CHAR_CR, CHAR_LF};

    bit in_fire = 1'b0;
    bit calm = 1'b0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int words_queued = 0;

    text_console_glyph_renderer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned clamp_side(logic [SIDE_W-1:0] v);
        return (int'(v) > MAX_GLYPH_SIDE) ? MAX_GLYPH_SIDE : int'(v);
    endfunction

    function automatic int unsigned font_addr(logic [7:0] code, int unsigned gx,
                                              int unsigned gy);
        int unsigned cw, ch, c, off, tx, ty, t;
        cw = clamp_side(glyph_w);
        ch = clamp_side(glyph_h);
        c = code;
        off = (c * cw * ch) & 32'hFFFF;
        tx = gx;
        ty = gy;
        if (attr_bits[ATTR_HFLIP]) tx = (cw - 1 - gx) & 32'hFFFF;
        if (attr_bits[ATTR_VFLIP]) ty = (ch - 1 - gy) & 32'hFFFF;
        if (attr_bits[ATTR_CW90]) begin
            t = (cw - 1 - tx) & 32'hFFFF;
            tx = ty;
            ty = t;
        end
        if (attr_bits[ATTR_CCW90]) begin
            t = (ch - 1 - ty) & 32'hFFFF;
            ty = tx;
            tx = t;
        end
        return ((off + tx + ty * cw) & 32'hFFFF) % FONT_ENTRIES;
    endfunction

    function automatic void predict_console_step(t_in_word w);
        t_out_word held;
        bit have;
        bit scroll;
        int unsigned cx, cy, cw, ch;
        held = '0;
        have = 1'b0;
        scroll = 1'b0;
        if (w.operation == OP_LOAD) begin
            font_bits[w.font_index] = w.font_bit;
            return;
        end
        cx = cur_col;
        cy = cur_row;
        cw = clamp_side(glyph_w);
        ch = clamp_side(glyph_h);
        if (cy < console_rows) begin
            case (w.char_code)
                CHAR_BS: begin
                    if (cx != 0) cx--;
                end
                CHAR_TAB: cx = (cx + TAB_STEP) / TAB_STEP * TAB_STEP;
                CHAR_CR:  cx = 0;
                CHAR_LF: begin
                    cx = 0;
                    cy++;
                end
                default: begin
                    for (int unsigned gy = 0; gy < ch; gy++) begin
                        for (int unsigned gx = 0; gx < cw; gx++) begin
                            if (have) pixel_cmds_due.push_back(held);
                            held = '0;
                            held.pixel_x = PX_W'(cx * cw + gx);
                            held.pixel_y = PY_W'(cy * ch + gy);
                            if (attr_bits[ATTR_NODRAW]) begin
                                held.write_kind = KIND_COLOR;
                                held.color = bg_idx;
                            end else if (font_bits[font_addr(w.char_code, gx, gy)]) begin
                                if (attr_bits[ATTR_REVERSE]) begin
                                    held.write_kind = KIND_INVERT;
                                end else begin
                                    held.write_kind = KIND_COLOR;
                                    held.color = fg_idx;
                                end
                            end else if (attr_bits[ATTR_MASKED] && bg_idx == 8'd0) begin
                                held.write_kind = KIND_KEEP;
                            end else begin
                                held.write_kind = KIND_COLOR;
                                held.color = bg_idx;
                            end
                            have = 1'b1;
                        end
                    end
                    cx++;
                end
            endcase
            if (cx >= console_cols) begin
                cx = 0;
                cy++;
            end
            if (cy >= console_rows && !attr_bits[ATTR_NOSCROLL]) begin
                scroll = 1'b1;
                cy--;
            end
            cur_col = COL_W'(cx);
            cur_row = ROW_W'(cy);
        end
        held.scroll_up = scroll;
        held.last = 1'b1;
        pixel_cmds_due.push_back(held);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void queue_load(int unsigned idx, bit value);
        t_in_word w;
        w.operation = OP_LOAD;
        w.char_code = 8'($urandom_range(0, 255));
        w.font_index = 14'(idx);
        w.font_bit = value;
        font_known[idx] = 1'b1;
        console_words_pending.push_back(w);
        words_queued++;
    endfunction

    // Any font entry the glyph will read is loaded first, so no put ever
    // touches memory that reset left undefined.
    function automatic void queue_put(logic [7:0] code);
        t_in_word w;
        int unsigned a;
        bit drawn;
        drawn = (code != CHAR_BS) && (code != CHAR_TAB) && (code != CHAR_CR) &&
                (code != CHAR_LF);
        if (drawn) begin
            for (int unsigned gy = 0; gy < clamp_side(glyph_h); gy++) begin
                for (int unsigned gx = 0; gx < clamp_side(glyph_w); gx++) begin
                    a = font_addr(code, gx, gy);
                    if (!font_known[a]) queue_load(a, 1'($urandom_range(0, 1)));
                end
            end
        end
        w.operation = OP_PUT;
        w.char_code = code;
        w.font_index = 14'($urandom_range(0, FONT_ENTRIES - 1));
        w.font_bit = 1'($urandom_range(0, 1));
        console_words_pending.push_back(w);
        words_queued++;
    endfunction

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_FG_COLOR:     fg_idx = data;
            CFG_BG_COLOR:     bg_idx = data;
            CFG_ATTR_FLAGS:   attr_bits = data;
            CFG_GLYPH_WIDTH:  glyph_w = data[SIDE_W-1:0];
            CFG_GLYPH_HEIGHT: glyph_h = data[SIDE_W-1:0];
            CFG_TEXT_COLUMNS: console_cols = data[COL_W-1:0];
            CFG_TEXT_ROWS:    console_rows = data[ROW_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_phase();
        while (console_words_pending.size() != 0 || in_valid || pixel_cmds_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic shuffle_config();
        int unsigned r, tmp;
        logic [7:0] pick;
        set_reg(CFG_FG_COLOR, 8'($urandom_range(0, 255)));
        set_reg(CFG_BG_COLOR, ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
        pick = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0) pick[ATTR_NOSCROLL] = 1'b0;
        set_reg(CFG_ATTR_FLAGS, pick);
        set_reg(CFG_GLYPH_WIDTH, ($urandom_range(0, 99) < 85) ? 8'($urandom_range(1, 8))
                                                           : 8'($urandom_range(0, 255)));
        set_reg(CFG_GLYPH_HEIGHT, ($urandom_range(0, 99) < 85) ? 8'($urandom_range(1, 8))
                                                            : 8'($urandom_range(0, 255)));
        r = $urandom_range(0, 99);
        if (r < 50) pick = 8'($urandom_range(1, 12));
        else if (r < 90) pick = 8'($urandom_range(1, 80));
        else pick = 8'($urandom_range(0, 255));
        set_reg(CFG_TEXT_COLUMNS, pick);
        r = $urandom_range(0, 99);
        tmp = cur_row + $urandom_range(1, 4);
        if (r < 70) pick = (tmp > ROW_MAX) ? 8'(ROW_MAX) : 8'(tmp);
        else if (r < 90) pick = 8'($urandom_range(1, 50));
        else pick = 8'($urandom_range(0, 255));
        set_reg(CFG_TEXT_ROWS, pick);
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_text_console_glyph_renderer_unit: done, errors");
            $finish;
        end else begin
            in_fire <= i_rst_n && in_valid && o_in_ready;
            if (i_rst_n && in_valid && o_in_ready) predict_console_step(in_word);
            if (i_rst_n && o_out_valid && out_ready) begin
                if (pixel_cmds_due.size() == 0) begin
                    $error("output word %h with nothing expected", o_out_data);
                    mismatch_count++;
                end else begin
                    want = pixel_cmds_due.pop_front();
                    check_field("write_kind", want.write_kind, o_out_data.write_kind);
                    check_field("pixel_x", want.pixel_x, o_out_data.pixel_x);
                    check_field("pixel_y", want.pixel_y, o_out_data.pixel_y);
                    check_field("color", want.color, o_out_data.color);
                    check_field("scroll_up", want.scroll_up, o_out_data.scroll_up);
                    check_field("last", want.last, o_out_data.last);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        if (i_rst_n && (!in_valid || in_fire)) begin
            if (console_words_pending.size() != 0 &&
                (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                in_valid <= 1'b1;
                in_word <= console_words_pending.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    initial begin
        int unsigned r;
        int phase_start;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: font extremes, code extremes and every control
        // character, including a backspace at the left edge.
        queue_load(0, 1'b1);
        queue_load(FONT_ENTRIES - 1, 1'b0);
        queue_put(8'h00);
        queue_put(8'hFF);
        queue_put(8'h41);
        queue_put(CHAR_BS);
        queue_put(CHAR_CR);
        queue_put(CHAR_BS);
        queue_put(CHAR_TAB);
        queue_put(CHAR_LF);
        drain_phase();

        // Tab past the last column and wrapping off the bottom both scroll.
        set_reg(CFG_SPARE, 8'hA5);
        set_reg(CFG_FG_COLOR, 8'hFF);
        set_reg(CFG_BG_COLOR, 8'h00);
        set_reg(CFG_ATTR_FLAGS, 8'((1 << ATTR_MASKED) | (1 << ATTR_REVERSE)));
        set_reg(CFG_GLYPH_WIDTH, 8'd5);
        set_reg(CFG_GLYPH_HEIGHT, 8'd7);
        set_reg(CFG_TEXT_COLUMNS, 8'd10);
        set_reg(CFG_TEXT_ROWS, 8'd2);
        queue_put(CHAR_TAB);
        queue_put(CHAR_TAB);
        queue_put(8'h42);
        queue_put(8'h43);
        queue_put(8'h44);
        queue_put(CHAR_LF);
        drain_phase();

        // Without scrolling the cursor leaves the screen and further puts
        // draw nothing. A flat glyph is rotated out of its own cell.
        set_reg(CFG_BG_COLOR, 8'h5A);
        set_reg(CFG_ATTR_FLAGS, 8'((1 << ATTR_NOSCROLL) | (1 << ATTR_HFLIP) |
                                   (1 << ATTR_VFLIP) | (1 << ATTR_CW90)));
        set_reg(CFG_GLYPH_WIDTH, 8'd8);
        set_reg(CFG_GLYPH_HEIGHT, 8'd1);
        set_reg(CFG_TEXT_COLUMNS, 8'd2);
        queue_put(8'h45);
        queue_put(8'h46);
        queue_put(8'h47);
        drain_phase();

        // Oversized width, zero height and zero columns.
        set_reg(CFG_ATTR_FLAGS, 8'((1 << ATTR_CCW90) | (1 << ATTR_NODRAW)));
        set_reg(CFG_GLYPH_WIDTH, 8'd15);
        set_reg(CFG_GLYPH_HEIGHT, 8'd0);
        set_reg(CFG_TEXT_COLUMNS, 8'd0);
        set_reg(CFG_TEXT_ROWS, 8'd50);
        queue_put(8'h48);
        queue_put(CHAR_CR);
        drain_phase();
        set_reg(CFG_GLYPH_HEIGHT, 8'd8);
        set_reg(CFG_TEXT_COLUMNS, 8'd80);
        queue_put(8'h49);
        drain_phase();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            shuffle_config();
            calm = (p == CALM_PHASE);
            phase_start = words_queued;
            while (words_queued - phase_start < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 10) queue_load($urandom_range(0, FONT_ENTRIES - 1),
                                       1'($urandom_range(0, 1)));
                else if (r < 30) queue_put(control_codes[$urandom_range(0, 3)]);
                else if (r < 85) queue_put(8'($urandom_range(65, 68)));
                else queue_put(8'($urandom_range(0, 255)));
            end
            drain_phase();
        end
        calm = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pixel_cmds_due.size() == 0) begin
            $display("tb_text_console_glyph_renderer_unit: done, clean");
        end else begin
            $display("tb_text_console_glyph_renderer_unit: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/tcgr_pkg.sv
rtl/tcgr_ram.sv
rtl/tcgr_regs.sv
rtl/tcgr_ctrl.sv
rtl/tcgr_datapath.sv
rtl/text_console_glyph_renderer_unit.sv
bench/tb_text_console_glyph_renderer_unit.sv
